// ===== src/drop_oldest_event_ring_core_assert.svh =====
// Assertion macros for the drop-oldest event ring.
// Needs a signal named clk and a signal named rst in the module that uses them.
`ifndef DROP_OLDEST_EVENT_RING_CORE_ASSERT_SVH
`define DROP_OLDEST_EVENT_RING_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every clock edge outside reset.
`define DEOR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("drop_oldest_event_ring_core: assertion failed");
// Next-cycle implication, checked at every clock edge outside reset.
`define DEOR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("drop_oldest_event_ring_core: assertion failed");
`else
`define DEOR_ASSERT_IMP(lbl, ante, cons)
`define DEOR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== src/deor_pkg.sv =====
// Shared types and constants for the drop-oldest event ring.
// No dependencies.
package deor_pkg;

  // Default ring depth in packets.
  localparam int DEOR_SLOTS = 64;

  // Width of the pending count on the result.
  localparam int PEND_W = 7;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EVICT = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One stored event packet.
  typedef struct packed {
    logic [63:0] stamp;
    logic [31:0] subject;
    logic [15:0] severity;
    logic [15:0] cause;
    logic [63:0] word_a;
    logic [63:0] word_b;
    logic [63:0] word_c;
  } packet_t;

  // Result information that the control block keeps for the current result.
  typedef struct packed {
    status_t            status;
    logic               pop_ok;
    logic [PEND_W-1:0]  pending;
    logic [63:0]        emitted;
    logic [63:0]        dropped;
  } res_info_t;

endpackage

// ===== src/deor_mem.sv =====
// Packet store of the ring: one write port, one read port with registered data.
// Depends on deor_pkg for the packet type.
module deor_mem
  import deor_pkg::*;
#(
  parameter int SLOTS = DEOR_SLOTS,
  parameter int AW    = $clog2(SLOTS)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  packet_t       wr_pkt,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output packet_t       rd_pkt
);

  packet_t mem [SLOTS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_pkt;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_pkt <= mem[rd_addr];
    end
  end

endmodule

// ===== src/deor_ctrl.sv =====
// Ring control: pointers, fill count, event counters and result status.
// Depends on deor_pkg for the status codes and the result information struct.
module deor_ctrl
  import deor_pkg::*;
#(
  parameter int SLOTS = DEOR_SLOTS,
  parameter int AW    = $clog2(SLOTS),
  parameter int CW    = $clog2(SLOTS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          op_pop,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  output logic [CW-1:0] fill,
  output res_info_t     res
);

  localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(SLOTS);

  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic [CW-1:0] count, count_next;
  logic [63:0]   emitted, emitted_next;
  logic [63:0]   dropped, dropped_next;
  status_t       status, status_next;
  logic          pop_ok, pop_ok_next;
  logic          is_full, is_empty;
  logic [31:0]   count_wide;

  assign is_full  = (count == FULL_CNT);
  assign is_empty = (count == '0);

  // Next state for one transfer.
  always_comb begin
    wr_ptr_next  = wr_ptr;
    rd_ptr_next  = rd_ptr;
    count_next   = count;
    emitted_next = emitted;
    dropped_next = dropped;
    status_next  = status;
    pop_ok_next  = pop_ok;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    if (accept) begin
      pop_ok_next = 1'b0;
      status_next = ST_OK;
      if (!op_pop) begin
        // A push on a full ring evicts the oldest packet; the count stays.
        wr_en        = 1'b1;
        wr_ptr_next  = (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
        emitted_next = emitted + 64'd1;
        if (is_full) begin
          rd_ptr_next  = (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
          dropped_next = dropped + 64'd1;
          status_next  = ST_EVICT;
        end else begin
          count_next = count + 1'b1;
        end
      end else if (is_empty) begin
        status_next = ST_EMPTY;
      end else begin
        rd_en       = 1'b1;
        pop_ok_next = 1'b1;
        rd_ptr_next = (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
        count_next  = count - 1'b1;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
      emitted <= '0;
      dropped <= '0;
      status  <= ST_OK;
      pop_ok  <= 1'b0;
    end else begin
      wr_ptr  <= wr_ptr_next;
      rd_ptr  <= rd_ptr_next;
      count   <= count_next;
      emitted <= emitted_next;
      dropped <= dropped_next;
      status  <= status_next;
      pop_ok  <= pop_ok_next;
    end
  end

  assign wr_addr    = wr_ptr;
  assign rd_addr    = rd_ptr;
  assign fill       = count;
  assign count_wide = 32'(count);

  // The state after the last transfer is the result of that transfer.
  assign res.status  = status;
  assign res.pop_ok  = pop_ok;
  assign res.pending = count_wide[PEND_W-1:0];
  assign res.emitted = emitted;
  assign res.dropped = dropped;

endmodule

// ===== src/drop_oldest_event_ring_core.sv =====
// Channel  Dir  Signals                       Contents
// s_       in   s_tvalid s_tready s_tdata     push or pop request
//                 s_tuser
// m_       out  m_tvalid m_tready m_tdata     status, popped packet, counters
//                 m_tuser
//
// One item per cycle while m_tready stays high: a push does one memory write, a pop
// at most one registered read; each pointer, count and counter moves by at most one.
// The result is shown in the cycle after its transfer and holds while m_tready is low.
// s_tready is high while the result register is empty or being taken.
// Reset clears pointers, count and counters; the packet store is not cleared.
//
// Top level of the drop-oldest event ring.
// Depends on deor_pkg, deor_ctrl, deor_mem and the assertion macro header.
`include "drop_oldest_event_ring_core_assert.svh"

module drop_oldest_event_ring_core
  import deor_pkg::*;
#(
  parameter int SLOTS = DEOR_SLOTS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // subject_id[31:0], severity[47:32], cause[63:48], word_a[127:64],
  // word_b[191:128], word_c[255:192], stamp[319:256]
  input  logic [319:0] s_tdata,
  // func[0], data_present[1]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_stamp[63:0], out_subject[95:64], out_severity[111:96],
  // out_cause[127:112], out_word_a[191:128], out_word_b[255:192],
  // out_word_c[319:256], pending[326:320], emitted_total[390:327],
  // dropped_total[454:391], zero[455]
  output logic [455:0] m_tdata,
  // status[1:0]
  output logic [1:0]   m_tuser
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic          s_accept;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [CW-1:0] fill;
  res_info_t     res;
  packet_t       wr_pkt, rd_pkt, out_pkt;
  logic          data_present;

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  // Packet built from the request; data words are zero when absent.
  assign data_present    = s_tuser[1];
  assign wr_pkt.subject  = s_tdata[31:0];
  assign wr_pkt.severity = s_tdata[47:32];
  assign wr_pkt.cause    = s_tdata[63:48];
  assign wr_pkt.word_a   = data_present ? s_tdata[127:64]  : 64'd0;
  assign wr_pkt.word_b   = data_present ? s_tdata[191:128] : 64'd0;
  assign wr_pkt.word_c   = data_present ? s_tdata[255:192] : 64'd0;
  assign wr_pkt.stamp    = s_tdata[319:256];

  deor_ctrl #(
    .SLOTS (SLOTS),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (s_accept),
    .op_pop  (s_tuser[0]),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .fill    (fill),
    .res     (res)
  );

  deor_mem #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_pkt  (wr_pkt),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_pkt  (rd_pkt)
  );

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Packet fields are shown only for a successful pop.
  assign out_pkt = res.pop_ok ? rd_pkt : '0;

  assign m_tdata = {1'b0, res.dropped, res.emitted, res.pending,
                    out_pkt.word_c, out_pkt.word_b, out_pkt.word_a,
                    out_pkt.cause, out_pkt.severity, out_pkt.subject,
                    out_pkt.stamp};
  assign m_tuser = res.status;

  // The fill count never passes the ring depth.
  `DEOR_ASSERT_IMP(a_fill_max, 1'b1, fill <= CW'(SLOTS))
  // An eviction is reported only with the ring still full.
  `DEOR_ASSERT_IMP(a_evict_full, m_tvalid && res.status == ST_EVICT, fill == CW'(SLOTS))
  // An empty pop leaves the ring empty and shows no packet.
  `DEOR_ASSERT_IMP(a_empty_pop, m_tvalid && res.status == ST_EMPTY, fill == '0 && !res.pop_ok)
  // Every accepted push bumps the emitted counter by one.
  `DEOR_ASSERT_NXT(a_push_count, s_accept && !s_tuser[0],
                   res.emitted == $past(res.emitted) + 64'd1)

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for drop_oldest_event_ring_core: push and pop requests with
// random payloads and random handshake gaps, each result checked against a ring predictor.
// Depends on deor_pkg and the drop_oldest_event_ring_core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deor_pkg::*;

  localparam int IDX_W        = $clog2(DEOR_SLOTS);
  localparam int RANDOM_ITEMS = 1150;
  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 200;
  localparam int HOLD_AT      = 400;
  localparam int DRAIN_CYCLES = 4;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } ring_op_t;

  typedef enum int {
    BURST_FLOOD,
    BURST_FILL,
    BURST_DRAIN,
    BURST_MIXED
  } burst_kind_t;

  // One request as it goes onto the input stream.
  typedef struct {
    ring_op_t    op;
    logic [31:0] subject;
    logic [15:0] severity;
    logic [15:0] cause;
    logic        data_present;
    logic [63:0] word_a;
    logic [63:0] word_b;
    logic [63:0] word_c;
    logic [63:0] stamp;
  } event_req_t;

  // One result as the ring should report it.
  typedef struct {
    status_t           status;
    packet_t           pkt;
    logic [PEND_W-1:0] pending;
    logic [63:0]       emitted;
    logic [63:0]       dropped;
  } ring_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // subject_id, severity, cause, word_a, word_b, word_c, stamp (lowest bits first)
  logic [319:0] s_tdata = '0;
  // func, data_present (lowest bit first)
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // out_stamp, out_subject, out_severity, out_cause, out_word_a, out_word_b,
  // out_word_c, pending, emitted_total, dropped_total, zero (lowest bits first)
  logic [455:0] m_tdata;
  // status
  logic [1:0]   m_tuser;

  event_req_t   event_req_q[$];
  ring_result_t ring_expect_q[$];

  // Shadow copy of the ring state.
  packet_t           shadow_ring [DEOR_SLOTS];
  logic [IDX_W-1:0]  shadow_wr = '0;
  logic [IDX_W-1:0]  shadow_rd = '0;
  logic [PEND_W-1:0] shadow_fill = '0;
  logic [63:0]       shadow_emitted = '0;
  logic [63:0]       shadow_dropped = '0;

  int  sent_count = 0;
  int  results_seen = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_left = 0;
  int  idle_cycles = 0;
  int  mismatch_count = 0;
  logic calm;

  // Some stretches run with no gaps on either side.
  assign calm = ((sent_count / 128) % 4) == 3;

  drop_oldest_event_ring_core #(
    .SLOTS(DEOR_SLOTS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [IDX_W-1:0] next_slot(logic [IDX_W-1:0] p);
    return (p == IDX_W'(DEOR_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  // Applies one request to the shadow ring and returns the result it should give.
  function automatic ring_result_t ring_outcome(event_req_t r);
    ring_result_t res;
    res.status = ST_OK;
    res.pkt = '0;
    if (r.op == OP_PUSH) begin
      // A full ring loses its oldest packet first.
      if (shadow_fill == DEOR_SLOTS) begin
        shadow_rd = next_slot(shadow_rd);
        shadow_fill--;
        shadow_dropped++;
        res.status = ST_EVICT;
      end
      shadow_ring[shadow_wr] = '{
        stamp:    r.stamp,
        subject:  r.subject,
        severity: r.severity,
        cause:    r.cause,
        word_a:   r.data_present ? r.word_a : 64'd0,
        word_b:   r.data_present ? r.word_b : 64'd0,
        word_c:   r.data_present ? r.word_c : 64'd0
      };
      shadow_wr = next_slot(shadow_wr);
      shadow_fill++;
      shadow_emitted++;
    end else if (shadow_fill == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.pkt = shadow_ring[shadow_rd];
      shadow_rd = next_slot(shadow_rd);
      shadow_fill--;
    end
    res.pending = shadow_fill;
    res.emitted = shadow_emitted;
    res.dropped = shadow_dropped;
    return res;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic event_req_t random_event(ring_op_t op);
    event_req_t r;
    r.op = op;
    r.subject = $urandom;
    r.severity = 16'($urandom);
    r.cause = 16'($urandom);
    r.data_present = 1'($urandom_range(0, 1));
    r.word_a = rand_word();
    r.word_b = rand_word();
    r.word_c = rand_word();
    r.stamp = rand_word();
    return r;
  endfunction

  // Every field set to the same bit pattern.
  function automatic event_req_t pattern_event(ring_op_t op, logic present, logic [63:0] fill);
    event_req_t r;
    r.op = op;
    r.subject = fill[31:0];
    r.severity = fill[15:0];
    r.cause = fill[15:0];
    r.data_present = present;
    r.word_a = fill;
    r.word_b = fill;
    r.word_c = fill;
    r.stamp = fill;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %h expected %h",
                                results_seen, name, got, want));
  endtask

  task automatic wait_for_drain();
    while (event_req_q.size() > 0 || ring_expect_q.size() > 0) @(posedge clk);
  endtask

  // Driver: offers the oldest queued request, holds it until the transfer,
  // then waits a random gap before the next one.
  always @(posedge clk) begin : driver
    logic next_valid;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      next_valid = s_tvalid && !s_tready;
      if (s_tvalid && s_tready) begin
        ring_expect_q.push_back(ring_outcome(event_req_q.pop_front()));
        sent_count++;
        send_gap = calm ? 0 : $urandom_range(0, 3);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (event_req_q.size() > 0) begin
          next_valid = 1'b1;
          s_tdata <= {event_req_q[0].stamp, event_req_q[0].word_c, event_req_q[0].word_b,
                      event_req_q[0].word_a, event_req_q[0].cause, event_req_q[0].severity,
                      event_req_q[0].subject};
          s_tuser <= {event_req_q[0].data_present, event_req_q[0].op};
        end
      end
      s_tvalid <= next_valid;
    end
  end

  // Monitor: checks each result transfer against the oldest expectation and
  // paces m_tready with random gaps and one long hold.
  always @(posedge clk) begin : monitor
    ring_result_t want;
    logic next_ready;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (ring_expect_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = ring_expect_q.pop_front();
          check_field("status", m_tuser, want.status);
          check_field("stamp", m_tdata[63:0], want.pkt.stamp);
          check_field("subject", m_tdata[95:64], want.pkt.subject);
          check_field("severity", m_tdata[111:96], want.pkt.severity);
          check_field("cause", m_tdata[127:112], want.pkt.cause);
          check_field("word_a", m_tdata[191:128], want.pkt.word_a);
          check_field("word_b", m_tdata[255:192], want.pkt.word_b);
          check_field("word_c", m_tdata[319:256], want.pkt.word_c);
          check_field("pending", m_tdata[326:320], want.pending);
          check_field("emitted", m_tdata[390:327], want.emitted);
          check_field("dropped", m_tdata[454:391], want.dropped);
        end
        recv_gap = calm ? 0 : $urandom_range(0, 3);
        if (results_seen == HOLD_AT) hold_left = LONG_HOLD;
      end
      next_ready = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
      end else if (recv_gap > 0) begin
        recv_gap--;
      end else begin
        next_ready = 1'b1;
      end
      m_tready <= next_ready;
    end
  end

  // Watchdog on stretches with no transfer on either side.
  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    burst_kind_t kind;
    ring_op_t    op;
    int          burst_len;
    int          produced;
    int          half;
    int          i;

    // Directed part: pop on an empty ring, pushes at the field extremes,
    // a push whose data words are dropped, then a full drain.
    event_req_q.push_back(pattern_event(OP_POP, 1'b1, '1));
    event_req_q.push_back(pattern_event(OP_PUSH, 1'b0, '0));
    event_req_q.push_back(pattern_event(OP_PUSH, 1'b1, '1));
    event_req_q.push_back(pattern_event(OP_PUSH, 1'b0, '1));
    event_req_q.push_back(pattern_event(OP_PUSH, 1'b1, {16{4'hA}}));
    event_req_q.push_back(pattern_event(OP_PUSH, 1'b1, {16{4'h5}}));
    for (i = 0; i < 6; i++) event_req_q.push_back(random_event(OP_POP));
    event_req_q.push_back(pattern_event(OP_POP, 1'b0, '0));
    for (i = 0; i < 3; i++) begin
      event_req_q.push_back(random_event(OP_PUSH));
      event_req_q.push_back(random_event(OP_POP));
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // The sender stops here until every result is in.
    wait_for_drain();

    // Random bursts: floods that can force evictions, fill and drain phases,
    // and even mixes. A pause for a full drain sits between the halves.
    for (half = 0; half < 2; half++) begin
      produced = 0;
      while (produced < RANDOM_ITEMS / 2) begin
        kind = burst_kind_t'($urandom_range(0, 3));
        case (kind)
          BURST_FLOOD: burst_len = $urandom_range(60, 80);
          BURST_DRAIN: burst_len = $urandom_range(30, 90);
          default:     burst_len = $urandom_range(10, 60);
        endcase
        for (i = 0; i < burst_len; i++) begin
          case (kind)
            BURST_FLOOD: op = OP_PUSH;
            BURST_FILL:  op = ($urandom_range(0, 9) < 8) ? OP_PUSH : OP_POP;
            BURST_DRAIN: op = ($urandom_range(0, 9) < 8) ? OP_POP : OP_PUSH;
            default:     op = ($urandom_range(0, 1) == 0) ? OP_PUSH : OP_POP;
          endcase
          event_req_q.push_back(random_event(op));
        end
        produced += burst_len;
      end
      wait_for_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
